>>> src/imu_fpp_pkg.sv
// ----------------------------------------------------------------------------
// imu_fpp_pkg
// Shared codes, register resets and conversion tables for the IMU FIFO
// packet parser.
// ----------------------------------------------------------------------------
package imu_fpp_pkg;

  localparam int unsigned PacketBytes  = 16;
  localparam int unsigned StoreIdxW    = $clog2(PacketBytes);
  localparam int unsigned EvtDepthDflt = 4;
  localparam int unsigned AddrW        = 5;
  localparam int unsigned DataW        = 32;

  localparam logic [31:0] AccelGainRst  = 32'd41132076;
  localparam logic [31:0] GyroGainRst   = 32'd4570790;
  localparam logic [15:0] SampleCapRst  = 16'hFFFF;
  localparam logic [7:0]  EmptyMaskRst  = 8'h80;
  localparam logic [7:0]  AccelMaskRst  = 8'h40;
  localparam logic [7:0]  GyroMaskRst   = 8'h20;

  typedef enum logic [2:0] {
    REG_ACCEL_GAIN  = 3'd0,
    REG_GYRO_GAIN   = 3'd1,
    REG_SAMPLE_CAP  = 3'd2,
    REG_EMPTY_MASK  = 3'd3,
    REG_ACCEL_MASK  = 3'd4,
    REG_GYRO_MASK   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    STOP_CONSUMED  = 3'd0,
    STOP_EMPTY     = 3'd1,
    STOP_UNKNOWN   = 3'd2,
    STOP_TRUNCATED = 3'd3,
    STOP_CAPACITY  = 3'd4
  } stop_reason_e;

  typedef enum logic [1:0] {
    PKT_ACCEL = 2'd0,
    PKT_GYRO  = 2'd1,
    PKT_BOTH  = 2'd2
  } pkt_type_e;

  typedef enum logic {
    RES_SAMPLE  = 1'b0,
    RES_SUMMARY = 1'b1
  } res_kind_e;

  // raw event straight out of the byte parser
  typedef struct packed {
    logic               smp;
    logic               sum;
    pkt_type_e          kind;
    logic [2:0][15:0]   acc_raw;
    logic [2:0][15:0]   gyr_raw;
    logic [7:0]         temp_byte;
    logic [15:0]        count;
    stop_reason_e       reason;
  } evt_raw_t;

  // event after the gain multipliers, before rounding
  typedef struct packed {
    logic               smp;
    logic               sum;
    pkt_type_e          kind;
    logic [2:0][47:0]   acc_prod;
    logic [2:0]         acc_neg;
    logic [2:0][47:0]   gyr_prod;
    logic [2:0]         gyr_neg;
    logic [15:0]        temp;
    logic [15:0]        count;
    stop_reason_e       reason;
  } evt_prod_t;

  // finished event as held in the output queue
  typedef struct packed {
    logic               smp;
    logic               sum;
    pkt_type_e          kind;
    logic [2:0][31:0]   acc;
    logic [2:0][31:0]   gyr;
    logic [15:0]        temp;
    logic [15:0]        count;
    stop_reason_e       reason;
  } evt_out_t;

  typedef logic [255:0][15:0] temp_lut_t;

  // Q8.8 celsius for every raw byte: raw / 2.07 + 25, rounded
  function automatic temp_lut_t build_temp_lut();
    temp_lut_t lut;
    int        mag;
    int        q;
    int        v;
    for (int i = 0; i < 256; i++) begin
      mag = (i < 128) ? i : 256 - i;
      q   = (mag * 51200 + 207) / 414;
      v   = (i < 128) ? 6400 + q : 6400 - q;
      lut[i] = v[15:0];
    end
    return lut;
  endfunction

  localparam temp_lut_t TempLut = build_temp_lut();

endpackage

>>> src/imu_fifo_packet_parser.sv
// ----------------------------------------------------------------------------
// imu_fifo_packet_parser
// Byte-wide parser for an IMU FIFO read-out that emits scaled samples and an
// end-of-buffer summary.
// ----------------------------------------------------------------------------
// One byte beat is taken per clock while in_ready_o is high. A result reaches
// the output through the parse register, the multiplier register and the
// output queue. A byte that both completes a packet and ends the buffer yields
// two result beats, the sample first. in_ready_o drops once the events in the
// two pipeline registers and the output queue together fill its EVT_DEPTH
// entries, so with out_ready_i held high the block sustains one byte per cycle.
// Six 16x32 gain multipliers work in parallel in the second stage.
module imu_fifo_packet_parser
  import imu_fpp_pkg::*;
#(
  parameter int unsigned EVT_DEPTH = EvtDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  // byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [1:0]         packet_type_o,
  output logic signed [31:0] accel_x_o,
  output logic signed [31:0] accel_y_o,
  output logic signed [31:0] accel_z_o,
  output logic signed [31:0] rate_x_o,
  output logic signed [31:0] rate_y_o,
  output logic signed [31:0] rate_z_o,
  output logic signed [15:0] temperature_o,
  output logic [15:0]        sample_count_o,
  output logic [2:0]         stop_reason_o
);

  localparam int unsigned PtrW = (EVT_DEPTH > 1) ? $clog2(EVT_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(EVT_DEPTH + 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] accel_gain_q, gyro_gain_q;
  logic [15:0] sample_cap_q;
  logic [7:0]  empty_mask_q, accel_mask_q, gyro_mask_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= AccelGainRst;
      gyro_gain_q  <= GyroGainRst;
      sample_cap_q <= SampleCapRst;
      empty_mask_q <= EmptyMaskRst;
      accel_mask_q <= AccelMaskRst;
      gyro_mask_q  <= GyroMaskRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACCEL_GAIN: accel_gain_q <= pwdata;
        REG_GYRO_GAIN:  gyro_gain_q  <= pwdata;
        REG_SAMPLE_CAP: sample_cap_q <= pwdata[15:0];
        REG_EMPTY_MASK: empty_mask_q <= pwdata[7:0];
        REG_ACCEL_MASK: accel_mask_q <= pwdata[7:0];
        REG_GYRO_MASK:  gyro_mask_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACCEL_GAIN: prdata = accel_gain_q;
      REG_GYRO_GAIN:  prdata = gyro_gain_q;
      REG_SAMPLE_CAP: prdata = {16'd0, sample_cap_q};
      REG_EMPTY_MASK: prdata = {24'd0, empty_mask_q};
      REG_ACCEL_MASK: prdata = {24'd0, accel_mask_q};
      REG_GYRO_MASK:  prdata = {24'd0, gyro_mask_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // byte parser
  // --------------------------------------------------------------------------
  logic [7:0]         store_q [PacketBytes];
  logic [7:0]         st_view [PacketBytes];
  logic [4:0]         pos_q, pos_d, pos_inc;
  logic [4:0]         len_q, len_d;
  pkt_type_e          kind_q, kind_d;
  logic [15:0]        cnt_q, cnt_d;
  logic               halt_q, halt_d;
  stop_reason_e       cause_q, cause_d;
  logic               st_wr, smp, sum, has_acc, has_gyr;
  logic [15:0]        sum_count;
  stop_reason_e       sum_reason;
  logic               in_fire;
  evt_raw_t           ev_n;

  assign in_fire = in_valid_i & in_ready_o;
  assign has_acc = |(data_byte_i & accel_mask_q);
  assign has_gyr = |(data_byte_i & gyro_mask_q);
  assign pos_inc = pos_q + 5'd1;

  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    halt_d  = halt_q;
    cause_d = cause_q;
    st_wr   = 1'b0;
    smp     = 1'b0;
    sum     = 1'b0;
    st_view = store_q;
    if (!halt_q) begin
      if (pos_q == '0) begin
        priority if (cnt_q >= sample_cap_q) begin
          halt_d  = 1'b1;
          cause_d = STOP_CAPACITY;
        end else if (|(data_byte_i & empty_mask_q)) begin
          halt_d  = 1'b1;
          cause_d = STOP_EMPTY;
        end else if (!has_acc && !has_gyr) begin
          halt_d  = 1'b1;
          cause_d = STOP_UNKNOWN;
        end else begin
          kind_d = (has_acc && has_gyr) ? PKT_BOTH : (has_acc ? PKT_ACCEL : PKT_GYRO);
          len_d  = (has_acc && has_gyr) ? 5'd16 : 5'd8;
          st_wr  = 1'b1;
          pos_d  = 5'd1;
        end
      end else begin
        st_wr = 1'b1;
        pos_d = pos_inc;
        if (pos_inc >= len_q) begin
          smp   = 1'b1;
          cnt_d = cnt_q + 16'd1;
          pos_d = '0;
        end
      end
    end
    if (st_wr) begin
      st_view[pos_q[StoreIdxW-1:0]] = data_byte_i;
    end
    sum_count  = cnt_d;
    sum_reason = halt_d ? cause_d : ((pos_d != '0) ? STOP_TRUNCATED : STOP_CONSUMED);
    if (last_byte_i) begin
      sum     = 1'b1;
      pos_d   = '0;
      len_d   = '0;
      cnt_d   = '0;
      halt_d  = 1'b0;
      cause_d = STOP_CONSUMED;
    end
  end

  // pick the axes out of the completed packet, zero where absent
  always_comb begin
    ev_n           = '0;
    ev_n.smp       = smp;
    ev_n.sum       = sum;
    ev_n.count     = sum_count;
    ev_n.reason    = sum_reason;
    ev_n.kind      = kind_q;
    ev_n.temp_byte = st_view[7];
    unique case (kind_q)
      PKT_GYRO: begin
        ev_n.gyr_raw[0] = {st_view[1], st_view[2]};
        ev_n.gyr_raw[1] = {st_view[3], st_view[4]};
        ev_n.gyr_raw[2] = {st_view[5], st_view[6]};
      end
      PKT_BOTH: begin
        ev_n.acc_raw[0] = {st_view[1], st_view[2]};
        ev_n.acc_raw[1] = {st_view[3], st_view[4]};
        ev_n.acc_raw[2] = {st_view[5], st_view[6]};
        ev_n.gyr_raw[0] = {st_view[7], st_view[8]};
        ev_n.gyr_raw[1] = {st_view[9], st_view[10]};
        ev_n.gyr_raw[2] = {st_view[11], st_view[12]};
        ev_n.temp_byte  = st_view[13];
      end
      default: begin
        ev_n.acc_raw[0] = {st_view[1], st_view[2]};
        ev_n.acc_raw[1] = {st_view[3], st_view[4]};
        ev_n.acc_raw[2] = {st_view[5], st_view[6]};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      kind_q  <= PKT_ACCEL;
      cnt_q   <= '0;
      halt_q  <= 1'b0;
      cause_q <= STOP_CONSUMED;
    end else if (in_fire) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      halt_q  <= halt_d;
      cause_q <= cause_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && st_wr) begin
      store_q[pos_q[StoreIdxW-1:0]] <= data_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: parsed event, stage 2: gain products
  // --------------------------------------------------------------------------
  logic      ev_vld_q, pr_vld_q;
  evt_raw_t  ev_q;
  evt_prod_t pr_n, pr_q;
  logic [2:0][15:0] acc_mag, gyr_mag;

  always_comb begin
    pr_n        = '0;
    pr_n.smp    = ev_q.smp;
    pr_n.sum    = ev_q.sum;
    pr_n.kind   = ev_q.kind;
    pr_n.count  = ev_q.count;
    pr_n.reason = ev_q.reason;
    pr_n.temp   = TempLut[ev_q.temp_byte];
    for (int i = 0; i < 3; i++) begin
      pr_n.acc_neg[i]  = ev_q.acc_raw[i][15];
      pr_n.gyr_neg[i]  = ev_q.gyr_raw[i][15];
      acc_mag[i]       = ev_q.acc_raw[i][15] ? (~ev_q.acc_raw[i] + 16'd1) : ev_q.acc_raw[i];
      gyr_mag[i]       = ev_q.gyr_raw[i][15] ? (~ev_q.gyr_raw[i] + 16'd1) : ev_q.gyr_raw[i];
      pr_n.acc_prod[i] = 48'(acc_mag[i]) * 48'(accel_gain_q);
      pr_n.gyr_prod[i] = 48'(gyr_mag[i]) * 48'(gyro_gain_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
      pr_vld_q <= 1'b0;
    end else begin
      ev_vld_q <= in_fire & (smp | sum);
      pr_vld_q <= ev_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_n;
    pr_q <= pr_n;
  end

  // round to nearest, ties away from zero, then restore the sign
  evt_out_t         fin;
  logic [2:0][47:0] acc_rnd, gyr_rnd;

  always_comb begin
    fin        = '0;
    fin.smp    = pr_q.smp;
    fin.sum    = pr_q.sum;
    fin.kind   = pr_q.kind;
    fin.temp   = pr_q.temp;
    fin.count  = pr_q.count;
    fin.reason = pr_q.reason;
    for (int i = 0; i < 3; i++) begin
      acc_rnd[i] = pr_q.acc_prod[i] + 48'd32768;
      gyr_rnd[i] = pr_q.gyr_prod[i] + 48'd32768;
      fin.acc[i] = pr_q.acc_neg[i] ? (32'd0 - acc_rnd[i][47:16]) : acc_rnd[i][47:16];
      fin.gyr[i] = pr_q.gyr_neg[i] ? (32'd0 - gyr_rnd[i][47:16]) : gyr_rnd[i][47:16];
    end
  end

  // --------------------------------------------------------------------------
  // output event queue
  // --------------------------------------------------------------------------
  evt_out_t          evq_q [EVT_DEPTH];
  evt_out_t          head;
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   evq_cnt_q;
  logic [CntW:0]     occ;
  logic              sub_q;
  logic              show_smp, out_fire, push, pop;

  assign push     = pr_vld_q;
  assign head     = evq_q[rd_ptr_q];
  assign show_smp = head.smp & ~sub_q;
  assign out_fire = out_valid_o & out_ready_i;
  assign pop      = out_fire & ~(show_smp & head.sum);
  assign occ      = (CntW+1)'(evq_cnt_q) + (CntW+1)'(ev_vld_q) + (CntW+1)'(pr_vld_q);
  assign in_ready_o  = occ < (CntW+1)'(EVT_DEPTH);
  assign out_valid_o = evq_cnt_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      evq_cnt_q <= '0;
      sub_q     <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(EVT_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(EVT_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   evq_cnt_q <= evq_cnt_q + CntW'(1);
        2'b01:   evq_cnt_q <= evq_cnt_q - CntW'(1);
        default: evq_cnt_q <= evq_cnt_q;
      endcase
      // sample beat of a two-beat event taken, summary still to go
      if (out_fire) begin
        sub_q <= ~pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      evq_q[wr_ptr_q] <= fin;
    end
  end

  assign result_kind_o  = show_smp ? RES_SAMPLE : RES_SUMMARY;
  assign packet_type_o  = show_smp ? head.kind : '0;
  assign accel_x_o      = show_smp ? head.acc[0] : '0;
  assign accel_y_o      = show_smp ? head.acc[1] : '0;
  assign accel_z_o      = show_smp ? head.acc[2] : '0;
  assign rate_x_o       = show_smp ? head.gyr[0] : '0;
  assign rate_y_o       = show_smp ? head.gyr[1] : '0;
  assign rate_z_o       = show_smp ? head.gyr[2] : '0;
  assign temperature_o  = show_smp ? head.temp : '0;
  assign sample_count_o = show_smp ? '0 : head.count;
  assign stop_reason_o  = show_smp ? '0 : head.reason;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_evq_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (evq_cnt_q < CntW'(EVT_DEPTH)) || pop)
    else $error("event queue written while full");

  a_evq_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evq_cnt_q <= CntW'(EVT_DEPTH))
    else $error("event queue count out of range");

  a_sub_two_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> out_valid_o && head.smp && head.sum)
    else $error("second beat pending on a one-beat event");

  a_last_gives_summary : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> ev_vld_q && ev_q.sum)
    else $error("last byte did not raise a summary");

  a_halt_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> pos_q == '0)
    else $error("byte position kept while halted");

endmodule

>>> test/imu_fifo_packet_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_fifo_packet_parser_tb
// Self-checking bench for the IMU FIFO packet parser. Byte beats are sent
// with random gaps and the result side stalls at random. A scoreboard
// predicts every sample and summary beat from the accepted bytes and the
// register settings, then checks each result beat in order.
// ----------------------------------------------------------------------------
module imu_fifo_packet_parser_tb;
  import imu_fpp_pkg::*;

  typedef struct packed {
    res_kind_e        kind;
    pkt_type_e        ptype;
    logic [2:0][31:0] accel;
    logic [2:0][31:0] rate;
    logic [15:0]      temp;
    logic [15:0]      count;
    stop_reason_e     reason;
  } imu_result_t;

  class sample_scoreboard;
    logic [31:0]  accel_gain  = AccelGainRst;
    logic [31:0]  gyro_gain   = GyroGainRst;
    logic [15:0]  capacity    = SampleCapRst;
    logic [7:0]   empty_mask  = EmptyMaskRst;
    logic [7:0]   accel_mask  = AccelMaskRst;
    logic [7:0]   gyro_mask   = GyroMaskRst;
    logic [7:0]   pkt_bytes [PacketBytes];
    int unsigned  fill;
    int unsigned  pkt_len;
    pkt_type_e    pkt_kind    = PKT_ACCEL;
    logic [15:0]  n_decoded   = '0;
    bit           stopped;
    stop_reason_e stop_cause  = STOP_CONSUMED;
    imu_result_t  predicted_results [$];
    int unsigned  errors;

    function void set_register(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_ACCEL_GAIN: accel_gain = value;
        REG_GYRO_GAIN:  gyro_gain  = value;
        REG_SAMPLE_CAP: capacity   = value[15:0];
        REG_EMPTY_MASK: empty_mask = value[7:0];
        REG_ACCEL_MASK: accel_mask = value[7:0];
        REG_GYRO_MASK:  gyro_mask  = value[7:0];
        default: ;
      endcase
    endfunction

    // bytes of the packet this header starts, 0 if it stops parsing
    function int unsigned packet_bytes(logic [7:0] header);
      if ((header & empty_mask) != 0) return 0;
      if ((header & accel_mask) != 0 && (header & gyro_mask) != 0) return 16;
      if ((header & (accel_mask | gyro_mask)) != 0) return 8;
      return 0;
    endfunction

    function int unsigned pending();
      return predicted_results.size();
    endfunction

    // raw * gain / 2^16, rounded half away from zero
    function logic [31:0] scaled_axis(logic [15:0] raw, logic [31:0] gain);
      logic [63:0] mag;
      logic [63:0] q;
      mag = {48'd0, raw};
      if (raw[15]) mag = 64'h1_0000 - mag;
      q = (mag * {32'd0, gain} + 64'd32768) >> 16;
      if (raw[15]) q = -q;
      return q[31:0];
    endfunction

    function logic [15:0] celsius_q8(logic [7:0] raw);
      int mag;
      int q;
      int v;
      mag = raw[7] ? 256 - int'(raw) : int'(raw);
      q   = (mag * 51200 + 207) / 414;
      v   = raw[7] ? 6400 - q : 6400 + q;
      return 16'(v);
    endfunction

    function logic [15:0] word_at(int unsigned pos);
      return {pkt_bytes[pos], pkt_bytes[pos + 1]};
    endfunction

    function void halt_on(stop_reason_e cause);
      stopped    = 1'b1;
      stop_cause = cause;
      fill       = 0;
    endfunction

    function void note_byte(logic [7:0] value, logic is_last);
      imu_result_t r;
      bit          has_acc;
      bit          has_gyr;
      if (!stopped) begin
        if (fill == 0) begin
          has_acc = (value & accel_mask) != 0;
          has_gyr = (value & gyro_mask) != 0;
          if (n_decoded >= capacity) begin
            halt_on(STOP_CAPACITY);
          end else if ((value & empty_mask) != 0) begin
            halt_on(STOP_EMPTY);
          end else if (!has_acc && !has_gyr) begin
            halt_on(STOP_UNKNOWN);
          end else begin
            pkt_kind     = (has_acc && has_gyr) ? PKT_BOTH : (has_acc ? PKT_ACCEL : PKT_GYRO);
            pkt_len      = (has_acc && has_gyr) ? 16 : 8;
            pkt_bytes[0] = value;
            fill         = 1;
          end
        end else begin
          pkt_bytes[fill % PacketBytes] = value;
          fill = (fill + 1) & 31;
          if (fill >= pkt_len) begin
            r       = '0;
            r.kind  = RES_SAMPLE;
            r.ptype = pkt_kind;
            if (pkt_kind == PKT_GYRO) begin
              for (int a = 0; a < 3; a++) r.rate[a] = scaled_axis(word_at(1 + 2 * a), gyro_gain);
              r.temp = celsius_q8(pkt_bytes[7]);
            end else begin
              for (int a = 0; a < 3; a++) r.accel[a] = scaled_axis(word_at(1 + 2 * a), accel_gain);
              if (pkt_kind == PKT_BOTH) begin
                for (int a = 0; a < 3; a++) r.rate[a] = scaled_axis(word_at(7 + 2 * a), gyro_gain);
                r.temp = celsius_q8(pkt_bytes[13]);
              end else begin
                r.temp = celsius_q8(pkt_bytes[7]);
              end
            end
            predicted_results.push_back(r);
            n_decoded++;
            fill = 0;
          end
        end
      end
      if (is_last) begin
        r        = '0;
        r.kind   = RES_SUMMARY;
        r.ptype  = PKT_ACCEL;
        r.count  = n_decoded;
        r.reason = stopped ? stop_cause : (fill != 0 ? STOP_TRUNCATED : STOP_CONSUMED);
        predicted_results.push_back(r);
        fill       = 0;
        pkt_len    = 0;
        n_decoded  = '0;
        stopped    = 1'b0;
        stop_cause = STOP_CONSUMED;
      end
    endfunction

    function void check_field(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %h, got %h", $time, what, want, seen);
        errors++;
      end
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t want;
      if (predicted_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, kind %0d", $time, got.kind);
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      check_field("result_kind", 32'(want.kind), 32'(got.kind));
      check_field("packet_type", 32'(want.ptype), 32'(got.ptype));
      check_field("accel_x", want.accel[0], got.accel[0]);
      check_field("accel_y", want.accel[1], got.accel[1]);
      check_field("accel_z", want.accel[2], got.accel[2]);
      check_field("rate_x", want.rate[0], got.rate[0]);
      check_field("rate_y", want.rate[1], got.rate[1]);
      check_field("rate_z", want.rate[2], got.rate[2]);
      check_field("temperature", 32'(want.temp), 32'(got.temp));
      check_field("sample_count", 32'(want.count), 32'(got.count));
      check_field("stop_reason", 32'(want.reason), 32'(got.reason));
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [AddrW-1:0]   paddr       = '0;
  logic [DataW-1:0]   pwdata      = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = '0;
  logic               last_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               result_kind_o;
  logic [1:0]         packet_type_o;
  logic signed [31:0] accel_x_o;
  logic signed [31:0] accel_y_o;
  logic signed [31:0] accel_z_o;
  logic signed [31:0] rate_x_o;
  logic signed [31:0] rate_y_o;
  logic signed [31:0] rate_z_o;
  logic signed [15:0] temperature_o;
  logic [15:0]        sample_count_o;
  logic [2:0]         stop_reason_o;

  sample_scoreboard sb = new;
  bit               quiet;
  bit               hold_request;
  int unsigned      random_items;
  logic [7:0]       seq [$];

  imu_fifo_packet_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .packet_type_o (packet_type_o),
    .accel_x_o     (accel_x_o),
    .accel_y_o     (accel_y_o),
    .accel_z_o     (accel_z_o),
    .rate_x_o      (rate_x_o),
    .rate_y_o      (rate_y_o),
    .rate_z_o      (rate_z_o),
    .temperature_o (temperature_o),
    .sample_count_o(sample_count_o),
    .stop_reason_o (stop_reason_o)
  );

  always #1 clk_i = ~clk_i;

  // note byte beats before result beats taken at the same edge
  always @(posedge clk_i) begin
    imu_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        got.kind     = res_kind_e'(result_kind_o);
        got.ptype    = pkt_type_e'(packet_type_o);
        got.accel[0] = accel_x_o;
        got.accel[1] = accel_y_o;
        got.accel[2] = accel_z_o;
        got.rate[0]  = rate_x_o;
        got.rate[1]  = rate_y_o;
        got.rate[2]  = rate_z_o;
        got.temp     = temperature_o;
        got.count    = sample_count_o;
        got.reason   = stop_reason_e'(stop_reason_o);
        sb.check_result(got);
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 16);
    end
  end

  function automatic logic [7:0] lowest_bit(logic [7:0] m);
    return m & (~m + 8'd1);
  endfunction

  function automatic logic [7:0] make_header(pkt_type_e kind);
    logic [7:0] h;
    h = 8'($urandom) & ~(sb.empty_mask | sb.accel_mask | sb.gyro_mask);
    if (kind != PKT_GYRO) h |= (sb.accel_mask & 8'($urandom)) | lowest_bit(sb.accel_mask);
    if (kind != PKT_ACCEL) h |= (sb.gyro_mask & 8'($urandom)) | lowest_bit(sb.gyro_mask);
    return h;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$], input logic end_buffer);
    foreach (bytes[i]) send_byte(bytes[i], end_buffer && i == bytes.size() - 1);
  endtask

  // block idle: every result in, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random_buffer();
    int unsigned n_pkts;
    int unsigned tail;
    int unsigned len;
    logic [7:0]  h;
    n_pkts = $urandom_range(0, 4);
    tail   = $urandom_range(0, 9);
    for (int p = 0; p < n_pkts; p++) begin
      h   = make_header(pkt_type_e'($urandom_range(0, 2)));
      len = sb.packet_bytes(h);
      if (len == 0) len = 1;
      for (int i = 0; i < len; i++) begin
        send_byte(i == 0 ? h : 8'($urandom), tail < 5 && p == n_pkts - 1 && i == len - 1);
        random_items++;
      end
    end
    if (tail < 5 && n_pkts != 0) return;
    // buffer ends on a stop, a cut packet or plain noise
    if (tail == 7) begin
      h   = make_header(pkt_type_e'($urandom_range(0, 2)));
      len = sb.packet_bytes(h);
      len = $urandom_range(1, len > 1 ? len - 1 : 1);
    end else begin
      case (tail)
        5:       h = 8'($urandom) | lowest_bit(sb.empty_mask);
        6:       h = 8'($urandom) & ~(sb.accel_mask | sb.gyro_mask);
        default: h = 8'($urandom);
      endcase
      len = $urandom_range(1, 6);
    end
    for (int i = 0; i < len; i++) begin
      send_byte(i == 0 ? h : 8'($urandom), i == len - 1);
      random_items++;
    end
  endtask

  initial begin
    #100000;
    $display("imu_fifo_packet_parser regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] ag;
    logic [31:0] gg;
    logic [15:0] cap;
    logic [7:0]  em;
    logic [7:0]  am;
    logic [7:0]  gm;
    int unsigned b0;
    int unsigned b1;
    int unsigned b2;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale accel gain so the most negative axis lands on -2^31
    write_reg(REG_ACCEL_GAIN, 32'hFFFF_FFFF);
    seq = '{8'h60, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00};
    send_bytes(seq, 1'b0);
    // accel mask cleared inside a packet: latched kind and length stay
    drain();
    write_reg(REG_ACCEL_MASK, 32'h0);
    seq = '{8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h7F, 8'hA5, 8'h5A};
    send_bytes(seq, 1'b0);
    // packet ends on the last byte: sample then summary
    seq = '{8'h20, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'h80};
    send_bytes(seq, 1'b1);
    seq = '{8'h80, 8'h33};
    send_bytes(seq, 1'b1);
    seq = '{8'h10};
    send_bytes(seq, 1'b1);
    seq = '{8'h20, 8'h11, 8'h22};
    send_bytes(seq, 1'b1);
    drain();
    write_reg(REG_SAMPLE_CAP, 32'h0);
    seq = '{8'h20};
    send_bytes(seq, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin ag = AccelGainRst; gg = GyroGainRst; end
        1: begin ag = '0; gg = '0; end
        3: begin ag = '1; gg = '1; end
        default: begin ag = $urandom; gg = $urandom; end
      endcase
      cap = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 4)) : 16'hFFFF;
      if (ph == 0) cap = SampleCapRst;
      b0 = $urandom_range(0, 7);
      b1 = (b0 + $urandom_range(1, 7)) % 8;
      do b2 = $urandom_range(0, 7); while (b2 == b0 || b2 == b1);
      em = 8'(1 << b0);
      am = 8'(1 << b1);
      gm = 8'(1 << b2);
      if (ph == 0) begin
        em = EmptyMaskRst;
        am = AccelMaskRst;
        gm = GyroMaskRst;
      end else if (ph == 4) begin
        // overlapping masks
        em = 8'($urandom) & 8'($urandom);
        am = 8'($urandom);
        gm = 8'($urandom);
      end else if (ph == 6) begin
        em = 8'h00;
        am = 8'hFF;
        gm = 8'hFF;
      end
      write_reg(REG_ACCEL_GAIN, ag);
      write_reg(REG_GYRO_GAIN, gg);
      write_reg(REG_SAMPLE_CAP, {16'd0, cap});
      write_reg(REG_EMPTY_MASK, {24'd0, em});
      write_reg(REG_ACCEL_MASK, {24'd0, am});
      write_reg(REG_GYRO_MASK, {24'd0, gm});
      quiet = (ph == 5);
      if (ph == 2) hold_request = 1'b1;
      while (random_items < (ph + 1) * 65) send_random_buffer();
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("imu_fifo_packet_parser regression: pass");
    end else begin
      $display("imu_fifo_packet_parser regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/imu_fpp_pkg.sv
src/imu_fifo_packet_parser.sv
test/imu_fifo_packet_parser_tb.sv
